// ===== rtl/tgarle_pkg.sv =====
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types, register indexes and format codes for the TGA RLE decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int MAX_RUN   = 128;

    // configuration register indexes
    localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [2:0] REG_PACKED_RUNS  = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_TOP_DOWN     = 3'd4;

    // pixel formats
    localparam logic [1:0] FMT_TC24  = 2'd0;
    localparam logic [1:0] FMT_TC32  = 2'd1;
    localparam logic [1:0] FMT_GREY8 = 2'd2;
    localparam logic [1:0] FMT_PAL8  = 2'd3;

    // input actions
    localparam logic ACT_PIXEL   = 1'b0;
    localparam logic ACT_PALETTE = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [6:0] HDR_LEN_MASK = 7'h7f;
    localparam int         HDR_RUN_BIT  = 7;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic        packed_runs;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        top_down;
    } cfg_t;

    typedef struct packed {
        logic [31:0] colour;
        logic        use_pal;
        logic        pal_zero;
        logic [7:0]  count;
        logic [15:0] row;
        logic [15:0] column;
        logic        done;
        logic        clipped;
    } beat_t;

    function automatic logic [2:0] bytes_needed(input logic [1:0] fmt);
        logic [2:0] n;
        case (fmt)
            FMT_TC24: n = 3'd3;
            FMT_TC32: n = 3'd4;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/tga_rle_image_decoder.sv =====
// A pixel byte that completes a pixel or run is registered in the parser stage, then
// in the result register together with the palette read.
// Throughput: one input beat per cycle unless both stages are full and m_ready is low.
// Header bytes, partial pixel bytes and palette writes give no result.
// Reset (aresetn, synchronous): clears packet, pixel, row/column and config state;
// the palette is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// tga_rle_image_decoder
// Decodes a TGA pixel byte stream into ARGB runs with memory row and column.
// ----------------------------------------------------------------------------
module tga_rle_image_decoder import tgarle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_entry_index,
    input  logic [31:0] s_entry_colour,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_argb,
    output logic [7:0]  m_repeat_count,
    output logic [15:0] m_mem_row,
    output logic [15:0] m_mem_column,
    output logic        m_image_done,
    output logic        m_run_clipped
);

    cfg_t        cfg;
    beat_t       s1_beat;
    logic        s1_valid;
    logic        out_free;
    logic        s1_take;
    logic        fire;
    logic        pal_wr;
    logic [31:0] pal_data;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid || m_ready;
    assign s1_take   = s1_valid && out_free;
    assign s_ready   = !s1_valid || out_free;
    assign fire      = s_valid && s_ready;
    assign pal_wr    = fire && (s_action == ACT_PALETTE)
                       && ({1'b0, s_entry_index} < 9'(PAL_DEPTH));

    tgarle_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tgarle_palette u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr),
        .wr_addr (s_entry_index[PAL_AW-1:0]),
        .wr_data (s_entry_colour),
        .rd_en   (fire && (s_action == ACT_PIXEL)),
        .rd_addr (s_data_byte[PAL_AW-1:0]),
        .rd_data (pal_data)
    );

    tgarle_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .fire      (fire),
        .s1_take   (s1_take),
        .action    (s_action),
        .data_byte (s_data_byte),
        .s1_valid  (s1_valid),
        .s1_beat   (s1_beat)
    );

    tgarle_out_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (s1_take),
        .beat           (s1_beat),
        .pal_data       (pal_data),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_pixel_argb   (m_pixel_argb),
        .m_repeat_count (m_repeat_count),
        .m_mem_row      (m_mem_row),
        .m_mem_column   (m_mem_column),
        .m_image_done   (m_image_done),
        .m_run_clipped  (m_run_clipped)
    );

endmodule

// ===== rtl/tgarle_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tgarle_cfg_regs
// Configuration register file written through the cfg channel.
// ----------------------------------------------------------------------------
module tgarle_cfg_regs import tgarle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_PIXEL_FORMAT: cfg_next.pixel_format = wr_data[1:0];
                REG_PACKED_RUNS:  cfg_next.packed_runs  = wr_data[0];
                REG_IMAGE_WIDTH:  cfg_next.image_width  = wr_data;
                REG_IMAGE_HEIGHT: cfg_next.image_height = wr_data;
                REG_TOP_DOWN:     cfg_next.top_down     = wr_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format <= FMT_TC24;
            cfg_reg.packed_runs  <= 1'b0;
            cfg_reg.image_width  <= 16'd1;
            cfg_reg.image_height <= 16'd1;
            cfg_reg.top_down     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tgarle_palette.sv =====
// ----------------------------------------------------------------------------
// tgarle_palette
// Palette memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tgarle_palette import tgarle_pkg::*; (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [PAL_AW-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [PAL_AW-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [PAL_DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tgarle_parser.sv =====
// ----------------------------------------------------------------------------
// tgarle_parser
// Packet and pixel assembly, row/column tracking and the first result stage.
// ----------------------------------------------------------------------------
module tgarle_parser import tgarle_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       fire,
    input  logic       s1_take,
    input  logic       action,
    input  logic [7:0] data_byte,
    output logic       s1_valid,
    output beat_t      s1_beat
);

    logic        expect_header_reg, expect_header_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [7:0]  packet_left_reg,   packet_left_next;
    logic [1:0]  byte_of_pixel_reg, byte_of_pixel_next;
    logic [23:0] pixel_bytes_reg,   pixel_bytes_next;
    logic [15:0] column_reg,        column_next;
    logic [15:0] row_reg,           row_next;
    logic        finished_reg,      finished_next;
    logic        s1_valid_reg,      s1_valid_next;
    beat_t       s1_beat_reg,       s1_beat_next;

    logic        data_fire;
    logic        hdr_byte;
    logic [2:0]  bop_inc;
    logic        partial;
    logic [23:0] shifted;
    logic [23:0] merged;
    logic [31:0] colour;
    logic [7:0]  count;
    logic [7:0]  left_dec;
    logic        in_row;
    logic [15:0] avail;
    logic [7:0]  rep;
    logic        clipped;
    logic [16:0] col_sum;
    logic        row_end;
    logic [15:0] row_inc;
    logic        done;
    logic [15:0] mrow;

    assign data_fire = fire && (action == ACT_PIXEL) && !finished_reg;
    assign hdr_byte  = cfg.packed_runs && expect_header_reg;
    assign bop_inc   = {1'b0, byte_of_pixel_reg} + 3'd1;
    assign partial   = bop_inc < bytes_needed(cfg.pixel_format);

    always_comb begin
        case (byte_of_pixel_reg)
            2'd0:    shifted = {16'd0, data_byte};
            2'd1:    shifted = {8'd0, data_byte, 8'd0};
            2'd2:    shifted = {data_byte, 16'd0};
            default: shifted = 24'd0;
        endcase
    end
    assign merged = pixel_bytes_reg | shifted;

    always_comb begin
        case (cfg.pixel_format)
            FMT_TC24:  colour = {ALPHA_OPAQUE, merged};
            FMT_TC32:  colour = {data_byte, merged};
            FMT_GREY8: colour = {ALPHA_OPAQUE, data_byte, data_byte, data_byte};
            default:   colour = 32'd0;
        endcase
    end

    assign left_dec = (packet_left_reg != 8'd0) ? packet_left_reg - 8'd1 : 8'd0;
    always_comb begin
        count = 8'd1;
        if (cfg.packed_runs && packet_is_run_reg && packet_left_reg != 8'd0) begin
            count = packet_left_reg;
        end
    end

    // clip the run at the row end
    assign in_row = column_reg < cfg.image_width;
    assign avail  = cfg.image_width - column_reg;
    always_comb begin
        if (!in_row) begin
            rep     = 8'd1;
            clipped = 1'b1;
        end else if ({8'd0, count} > avail) begin
            rep     = avail[7:0];
            clipped = 1'b1;
        end else begin
            rep     = count;
            clipped = 1'b0;
        end
    end

    assign mrow    = cfg.top_down ? row_reg : cfg.image_height - 16'd1 - row_reg;
    assign col_sum = {1'b0, column_reg} + {9'd0, rep};
    assign row_end = col_sum >= {1'b0, cfg.image_width};
    assign row_inc = row_reg + 16'd1;
    assign done    = row_end && ((row_inc >= cfg.image_height) || (row_inc == 16'd0));

    always_comb begin
        expect_header_next = expect_header_reg;
        packet_is_run_next = packet_is_run_reg;
        packet_left_next   = packet_left_reg;
        byte_of_pixel_next = byte_of_pixel_reg;
        pixel_bytes_next   = pixel_bytes_reg;
        column_next        = column_reg;
        row_next           = row_reg;
        finished_next      = finished_reg;
        s1_valid_next      = s1_take ? 1'b0 : s1_valid_reg;
        s1_beat_next       = s1_beat_reg;

        if (data_fire) begin
            if (hdr_byte) begin
                packet_is_run_next = data_byte[HDR_RUN_BIT];
                packet_left_next   = {1'b0, data_byte[6:0] & HDR_LEN_MASK} + 8'd1;
                expect_header_next = 1'b0;
                byte_of_pixel_next = 2'd0;
                pixel_bytes_next   = 24'd0;
            end else if (partial) begin
                pixel_bytes_next   = merged;
                byte_of_pixel_next = byte_of_pixel_reg + 2'd1;
            end else begin
                byte_of_pixel_next = 2'd0;
                pixel_bytes_next   = 24'd0;
                if (cfg.packed_runs) begin
                    if (packet_is_run_reg) begin
                        packet_left_next   = 8'd0;
                        expect_header_next = 1'b1;
                    end else begin
                        packet_left_next = left_dec;
                        if (left_dec == 8'd0) begin
                            expect_header_next = 1'b1;
                        end
                    end
                end
                column_next   = row_end ? 16'd0 : col_sum[15:0];
                row_next      = row_end ? row_inc : row_reg;
                finished_next = done;

                s1_valid_next         = 1'b1;
                s1_beat_next.colour   = colour;
                s1_beat_next.use_pal  = (cfg.pixel_format == FMT_PAL8);
                s1_beat_next.pal_zero = {1'b0, data_byte} >= 9'(PAL_DEPTH);
                s1_beat_next.count    = rep;
                s1_beat_next.row      = mrow;
                s1_beat_next.column   = column_reg;
                s1_beat_next.done     = done;
                s1_beat_next.clipped  = clipped;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            packet_left_reg   <= 8'd0;
            byte_of_pixel_reg <= 2'd0;
            pixel_bytes_reg   <= 24'd0;
            column_reg        <= 16'd0;
            row_reg           <= 16'd0;
            finished_reg      <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end else begin
            expect_header_reg <= expect_header_next;
            packet_is_run_reg <= packet_is_run_next;
            packet_left_reg   <= packet_left_next;
            byte_of_pixel_reg <= byte_of_pixel_next;
            pixel_bytes_reg   <= pixel_bytes_next;
            column_reg        <= column_next;
            row_reg           <= row_next;
            finished_reg      <= finished_next;
            s1_valid_reg      <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_beat_reg <= s1_beat_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_beat  = s1_beat_reg;

endmodule

// ===== rtl/tgarle_out_reg.sv =====
// ----------------------------------------------------------------------------
// tgarle_out_reg
// Result register: merges the palette read into the colour and holds the beat.
// ----------------------------------------------------------------------------
module tgarle_out_reg import tgarle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  beat_t       beat,
    input  logic [31:0] pal_data,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [31:0] m_pixel_argb,
    output logic [7:0]  m_repeat_count,
    output logic [15:0] m_mem_row,
    output logic [15:0] m_mem_column,
    output logic        m_image_done,
    output logic        m_run_clipped
);

    logic  valid_reg, valid_next;
    beat_t beat_reg,  beat_next;

    always_comb begin
        valid_next = (m_ready && valid_reg) ? 1'b0 : valid_reg;
        beat_next  = beat_reg;
        if (load) begin
            valid_next = 1'b1;
            beat_next  = beat;
            if (beat.use_pal) begin
                beat_next.colour = beat.pal_zero ? 32'd0 : pal_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

    assign m_valid        = valid_reg;
    assign m_pixel_argb   = beat_reg.colour;
    assign m_repeat_count = beat_reg.count;
    assign m_mem_row      = beat_reg.row;
    assign m_mem_column   = beat_reg.column;
    assign m_image_done   = beat_reg.done;
    assign m_run_clipped  = beat_reg.clipped;

endmodule

// ===== rtl/tgarle_checker.sv =====
// ----------------------------------------------------------------------------
// tgarle_checker
// Port-level checks on the decoder input stall and result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tgarle_checker import tgarle_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_pixel_argb,
    input logic [7:0]  m_repeat_count,
    input logic [15:0] m_mem_row,
    input logic [15:0] m_mem_column,
    input logic        m_image_done
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_argb)
        && $stable(m_repeat_count) && $stable(m_mem_row) && $stable(m_mem_column))
        else $error("result beat changed while stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_repeat_count != 8'd0) && (m_repeat_count <= 8'(MAX_RUN)))
        else $error("repeat count out of range");

    // nothing follows the beat that finishes the image
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_image_done |=> !m_valid)
        else $error("result after image done");

    // input only stalls when both stages are full
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with free result register");

endmodule

bind tga_rle_image_decoder tgarle_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_pixel_argb   (m_pixel_argb),
    .m_repeat_count (m_repeat_count),
    .m_mem_row      (m_mem_row),
    .m_mem_column   (m_mem_column),
    .m_image_done   (m_image_done)
);
